// ----- rtl/core/bdb_pkg.sv -----
// Shared constants, register indexes and sequencer states of the beat detector.
package bdb_pkg;

	// Field widths fixed by the frame and result formats
	localparam int TIME_W     = 32;
	localparam int LEVEL_W    = 16;
	localparam int THR_W      = 17;
	localparam int MS_W       = 16;
	localparam int BPM_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Ring depth default and the beats-per-minute scale (ms per minute)
	localparam int MAX_BEATS_DEF = 64;
	localparam int BPM_SCALE     = 60000;
	localparam int BPM_MAX       = 65535;

	// Register reset values
	localparam logic [THR_W-1:0]  THR_RST    = THR_W'(19661);
	localparam logic [MS_W-1:0]   SUSTAIN_RST = MS_W'(150);
	localparam logic [MS_W-1:0]   IGNORE_RST = MS_W'(250);
	localparam logic [TIME_W-1:0] WINDOW_RST = TIME_W'(10000);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD = 2'd0,
		CFG_SUSTAIN   = 2'd1,
		CFG_IGNORE    = 2'd2,
		CFG_WINDOW    = 2'd3
	} cfg_idx_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PUSH,
		ST_DROP_RD,
		ST_DROP_CHK,
		ST_TMR_A,
		ST_TMR_B,
		ST_OLD_RD,
		ST_NEW_RD,
		ST_SPAN,
		ST_MUL,
		ST_DIV,
		ST_FINISH
	} seq_state_t;

endpackage

// ----- rtl/core/bdb_if.sv -----
// Frame input and result output channel interfaces.
interface bdb_in_if
	import bdb_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [TIME_W-1:0]  time_ms;
	logic [LEVEL_W-1:0] left_level;
	logic [LEVEL_W-1:0] right_level;

	modport source (output valid, output time_ms, output left_level, output right_level,
		input ready);
	modport sink (input valid, input time_ms, input left_level, input right_level,
		output ready);
endinterface

interface bdb_out_if
	import bdb_pkg::*;
#(
	parameter int CNT_W = 7
);
	logic             valid;
	logic             ready;
	logic             beat;
	logic [BPM_W-1:0] bpm;
	logic [CNT_W-1:0] beats_tracked;

	modport source (output valid, output beat, output bpm, output beats_tracked,
		input ready);
	modport sink (input valid, input beat, input bpm, input beats_tracked,
		output ready);
endinterface

// ----- rtl/core/bdb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bdb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ----- rtl/core/bdb_div.sv -----
// Restoring divider: one quotient bit per cycle.
module bdb_div #(
	parameter int NUM_W = 22,
	parameter int DEN_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [NUM_W-1:0] quotient
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	// Shift in the next dividend bit and trial-subtract
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	// Control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DEN_W'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[DEN_W-1:0];
			end
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// ----- rtl/core/beat_detect_bpm_estimator_top.sv -----
// Beat detector with tempo estimate: sequencer, beat-time ring and divider.
//
//  channel     dir  handshake          payload
//  frame_in    in   valid/ready        time_ms[31:0] left_level[15:0] right_level[15:0]
//  result_out  out  valid/ready        beat bpm[15:0] beats_tracked[CNT_W-1:0]
//  cfg         in   cfg_we (no wait)   cfg_index[1:0] cfg_data[31:0]
//
// One frame at a time: the next frame is taken only once the sequencer is back in idle.
// A frame with a beat pushes its time and walks the one-read-port ring to drop aged beats;
// the timers update, then the oldest and newest beats feed the one-bit-per-cycle divider.
// Fewer than two tracked beats or a zero span skip the divider.
// Reset clears the sequencer, tick marks, ring pointers and result valid, and presets the
// config registers; the ring contents need no clearing since only live entries are read.
// A stalled result holds in the output register while the next frame is taken; that frame
// then waits in its last step until the register frees.
module beat_detect_bpm_estimator_top
	import bdb_pkg::*;
#(
	parameter int MAX_BEATS = MAX_BEATS_DEF,
	parameter int CNT_W     = $clog2(MAX_BEATS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	bdb_in_if.sink                frame_in,
	bdb_out_if.source             result_out,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int AW    = $clog2(MAX_BEATS);
	localparam int IW    = CNT_W + 1;
	localparam int NUM_W = $clog2(BPM_SCALE * (MAX_BEATS - 1) + 1);

	// Configuration registers
	logic [THR_W-1:0]  thr_q;
	logic [MS_W-1:0]   sustain_q;
	logic [MS_W-1:0]   ignore_len_q;
	logic [TIME_W-1:0] window_q;

	// Detector state
	seq_state_t        state_q, state_d;
	logic [TIME_W-1:0] now_q;
	logic              hit_q;
	logic [TIME_W-1:0] last_q;
	logic [TIME_W-1:0] ign_q;
	logic              pending_q;
	logic              fired_q;
	logic              beat_q;
	logic [AW-1:0]     head_q;
	logic [CNT_W-1:0]  count_q;
	logic [TIME_W-1:0] oldest_q;
	logic [TIME_W-1:0] span_q;
	logic [BPM_W-1:0]  bpm_q;

	// Result register
	logic              out_valid_q;
	logic              out_beat_q;
	logic [BPM_W-1:0]  out_bpm_q;
	logic [CNT_W-1:0]  out_cnt_q;

	// Ring and divider connections
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [AW-1:0]     ram_raddr;
	logic [TIME_W-1:0] ram_rdata;
	logic              div_start;
	logic [NUM_W-1:0]  div_num;
	logic              div_done;
	logic [NUM_W-1:0]  div_quo;

	// Derived control terms
	logic [LEVEL_W:0]  level_sum;
	logic              in_fire;
	logic              fire_now;
	logic              ring_full;
	logic [IW-1:0]     tail_sum;
	logic [IW-1:0]     newest_sum;
	logic [AW-1:0]     tail_idx;
	logic [AW-1:0]     newest_idx;
	logic [AW-1:0]     head_next;
	logic              too_old;
	logic              hold_beat;
	logic              ignore_over;
	logic              out_free;

	assign level_sum = {1'b0, frame_in.left_level} + {1'b0, frame_in.right_level};
	assign in_fire   = frame_in.valid && frame_in.ready;
	assign fire_now  = hit_q && (last_q == '0) && (ign_q == '0);
	assign ring_full = count_q == CNT_W'(MAX_BEATS);

	// Ring indexes modulo the depth
	assign tail_sum   = IW'(head_q) + IW'(count_q);
	assign tail_idx   = (tail_sum >= IW'(MAX_BEATS)) ? AW'(tail_sum - IW'(MAX_BEATS))
	                                                : tail_sum[AW-1:0];
	assign newest_sum = tail_sum - IW'(1);
	assign newest_idx = (newest_sum >= IW'(MAX_BEATS)) ? AW'(newest_sum - IW'(MAX_BEATS))
	                                                  : newest_sum[AW-1:0];
	assign head_next  = (head_q == AW'(MAX_BEATS - 1)) ? '0 : head_q + 1'b1;

	// Timer and age compares
	assign too_old     = (now_q - ram_rdata) > window_q;
	assign hold_beat   = ((now_q - last_q) < TIME_W'(sustain_q)) && pending_q;
	assign ignore_over = (now_q - ign_q) >= TIME_W'(ignore_len_q);
	assign out_free    = !out_valid_q || result_out.ready;

	// Accept a frame only while the sequencer is idle and holds no frame
	assign frame_in.ready = (state_q == ST_IDLE) && !fired_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q        <= THR_RST;
			sustain_q    <= SUSTAIN_RST;
			ignore_len_q <= IGNORE_RST;
			window_q     <= WINDOW_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_THRESHOLD: thr_q        <= cfg_data[THR_W-1:0];
				CFG_SUSTAIN:   sustain_q    <= cfg_data[MS_W-1:0];
				CFG_IGNORE:    ignore_len_q <= cfg_data[MS_W-1:0];
				CFG_WINDOW:    window_q     <= cfg_data[TIME_W-1:0];
				default:       ;
			endcase
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			// Enter the push step first when the latched frame fires a beat
			ST_IDLE:     if (fired_q) state_d = fire_now ? ST_PUSH : ST_TMR_A;
			ST_PUSH:     state_d = ST_DROP_RD;
			ST_DROP_RD:  state_d = ST_DROP_CHK;
			ST_DROP_CHK: state_d = (count_q != '0 && too_old) ? ST_DROP_RD : ST_TMR_A;
			ST_TMR_A:    state_d = ST_TMR_B;
			ST_TMR_B:    state_d = (count_q < CNT_W'(2)) ? ST_FINISH : ST_OLD_RD;
			ST_OLD_RD:   state_d = ST_NEW_RD;
			ST_NEW_RD:   state_d = ST_SPAN;
			ST_SPAN:     state_d = ST_MUL;
			ST_MUL:      state_d = (span_q == '0) ? ST_FINISH : ST_DIV;
			ST_DIV:      if (div_done) state_d = ST_FINISH;
			ST_FINISH:   if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Ring and divider controls
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = tail_idx;
		ram_raddr = head_q;
		div_start = 1'b0;
		div_num   = NUM_W'(BPM_SCALE) * NUM_W'(count_q - 1'b1);
		unique case (state_q)
			ST_PUSH: begin
				ram_we    = 1'b1;
				ram_waddr = tail_idx;
			end
			ST_NEW_RD: ram_raddr = newest_idx;
			ST_MUL:    div_start = span_q != '0;
			default:   ;
		endcase
	end

	// Sequencer state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fired_q     <= 1'b0;
			last_q      <= '0;
			ign_q       <= '0;
			pending_q   <= 1'b0;
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// Flag a latched frame so that the idle state decides on the beat
			fired_q <= in_fire;
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_PUSH: begin
					last_q    <= now_q;
					pending_q <= 1'b1;
					if (ring_full) begin
						head_q <= head_next;
					end else begin
						count_q <= count_q + 1'b1;
					end
				end
				ST_DROP_CHK: begin
					if (count_q != '0 && too_old) begin
						head_q  <= head_next;
						count_q <= count_q - 1'b1;
					end
				end
				ST_TMR_A: begin
					if (hold_beat) begin
						pending_q <= 1'b0;
					end else if (ign_q == '0 && last_q != '0) begin
						last_q <= '0;
						ign_q  <= now_q;
					end
				end
				ST_TMR_B: begin
					if (ignore_over) begin
						ign_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			now_q <= frame_in.time_ms;
			hit_q <= level_sum >= thr_q;
		end
		unique case (state_q)
			ST_TMR_B:  bpm_q    <= '0;
			ST_NEW_RD: oldest_q <= ram_rdata;
			ST_SPAN:   span_q   <= ram_rdata - oldest_q;
			ST_DIV: begin
				if (div_done) begin
					bpm_q <= (div_quo > NUM_W'(BPM_MAX)) ? BPM_W'(BPM_MAX) : div_quo[BPM_W-1:0];
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					out_bpm_q <= bpm_q;
					out_cnt_q <= count_q;
				end
			end
			default: ;
		endcase
	end

	// Remember whether this frame fired, for the result
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && fired_q) begin
			beat_q <= fire_now;
		end
		if (state_q == ST_FINISH && out_free) begin
			out_beat_q <= beat_q;
		end
	end

	bdb_ram #(
		.WIDTH(TIME_W),
		.DEPTH(MAX_BEATS)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(now_q),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	bdb_div #(
		.NUM_W(NUM_W),
		.DEN_W(TIME_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_num),
		.divisor (span_q),
		.done    (div_done),
		.quotient(div_quo)
	);

	// Drive the result channel
	assign result_out.valid         = out_valid_q;
	assign result_out.beat          = out_beat_q;
	assign result_out.bpm           = out_bpm_q;
	assign result_out.beats_tracked = out_cnt_q;
endmodule

// ----- tb/beat_detect_bpm_estimator_top_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the beat detector: frame driver, result checker, tempo predictor.
module beat_detect_bpm_estimator_top_tb
	import bdb_pkg::*;
;

	localparam int RING      = MAX_BEATS_DEF;
	localparam int CNT_W     = $clog2(RING + 1);
	localparam int QUIET_MAX = 5000;
	localparam int LONG_HOLD = 400;
	localparam int TAIL      = 200;

	typedef struct {
		logic [TIME_W-1:0]  t;
		logic [LEVEL_W-1:0] left;
		logic [LEVEL_W-1:0] right;
	} frame_t;

	typedef struct {
		logic             beat;
		logic [BPM_W-1:0] bpm;
		logic [CNT_W-1:0] tracked;
	} tempo_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bdb_in_if                   frm_if ();
	bdb_out_if #(.CNT_W(CNT_W)) res_if ();

	beat_detect_bpm_estimator_top #(
		.MAX_BEATS(RING),
		.CNT_W    (CNT_W)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame_in  (frm_if),
		.result_out(res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Register copies and detector state of the predictor
	logic [THR_W-1:0]  thr_cfg;
	logic [MS_W-1:0]   sustain_cfg;
	logic [MS_W-1:0]   ignore_cfg;
	logic [TIME_W-1:0] window_cfg;
	logic [TIME_W-1:0] beat_mark;
	logic [TIME_W-1:0] ignore_mark;
	bit                beat_held;
	bit [TIME_W-1:0]   beat_times [RING];
	int unsigned       times_head;
	int unsigned       times_count;

	// Pending frames, expected results and bookkeeping
	frame_t      frame_q [$];
	tempo_t      tempo_q [$];
	frame_t      next_frame;
	tempo_t      want;
	logic [TIME_W-1:0] stream_ms;
	int unsigned queued_total;
	int unsigned frames_taken;
	int unsigned results_seen;
	int unsigned error_count;
	int unsigned beat_total;
	int unsigned sat_total;
	int unsigned overwrite_total;
	int unsigned peak_tracked;
	int unsigned cfg_writes;
	int unsigned gap_left;
	int unsigned stall_left;
	int unsigned quiet_cycles;
	bit          send_gaps;
	bit          take_stalls;
	int unsigned hold_reqs;
	int unsigned hold_acks;

	// Advance the detector by one frame and return the result it must give
	function automatic tempo_t predict_tempo(frame_t f);
		logic [THR_W-1:0]  level_sum;
		logic [TIME_W-1:0] age;
		logic [TIME_W-1:0] span;
		longint unsigned   ratio;
		tempo_t            res;
		level_sum = THR_W'(f.left) + THR_W'(f.right);
		res.beat = 1'b0;
		// fire when loud enough and neither tick mark is set
		if (level_sum >= thr_cfg && beat_mark == '0 && ignore_mark == '0) begin
			beat_mark = f.t;
			if (times_count >= RING) begin
				beat_times[times_head] = f.t;
				times_head = (times_head + 1) % RING;
				overwrite_total++;
			end else begin
				beat_times[(times_head + times_count) % RING] = f.t;
				times_count++;
			end
			// drop beat times older than the tracking window
			age = f.t - beat_times[times_head];
			while (times_count > 0 && age > window_cfg) begin
				times_head = (times_head + 1) % RING;
				times_count--;
				age = f.t - beat_times[times_head];
			end
			beat_held = 1'b1;
			res.beat = 1'b1;
			beat_total++;
		end
		// hold the beat for the sustain time, then open the ignore window
		age = f.t - beat_mark;
		if (age < TIME_W'(sustain_cfg) && beat_held) begin
			beat_held = 1'b0;
		end else if (ignore_mark == '0 && beat_mark != '0) begin
			beat_mark = '0;
			ignore_mark = f.t;
		end
		// close the ignore window once it has run out
		age = f.t - ignore_mark;
		if (age >= TIME_W'(ignore_cfg))
			ignore_mark = '0;
		// tempo from the oldest and newest tracked beat
		res.bpm = '0;
		if (times_count >= 2) begin
			span = beat_times[(times_head + times_count - 1) % RING] - beat_times[times_head];
			if (span != '0) begin
				ratio = (64'(BPM_SCALE) * 64'(times_count - 1)) / 64'(span);
				if (ratio > 64'(BPM_MAX)) begin
					res.bpm = BPM_W'(BPM_MAX);
					sat_total++;
				end else begin
					res.bpm = BPM_W'(ratio);
				end
			end
		end
		res.tracked = CNT_W'(times_count);
		if (times_count > peak_tracked)
			peak_tracked = times_count;
		return res;
	endfunction

	// Print one mismatch line and count it
	task automatic report_mismatch(string msg);
		error_count++;
		if (error_count <= 100)
			$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	// Pick levels: loud, quiet, or right at the threshold
	function automatic frame_t make_frame(logic [TIME_W-1:0] t);
		frame_t      f;
		int unsigned pick;
		int unsigned target;
		f.t = t;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			f.left = LEVEL_W'($urandom());
			f.right = LEVEL_W'($urandom());
		end else if (pick < 80) begin
			f.left = LEVEL_W'($urandom_range(0, 4095));
			f.right = LEVEL_W'($urandom_range(0, 4095));
		end else begin
			target = thr_cfg + $urandom_range(0, 2);
			if (target > 0)
				target = target - 1;
			if (target > 131070)
				target = 131070;
			f.left = LEVEL_W'(target / 2);
			f.right = LEVEL_W'(target - target / 2);
		end
		return f;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (!send_gaps || roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic queue_frame(logic [TIME_W-1:0] t, logic [LEVEL_W-1:0] l,
		logic [LEVEL_W-1:0] r);
		frame_t f;
		f.t = t;
		f.left = l;
		f.right = r;
		frame_q.push_back(f);
		queued_total++;
	endtask

	// Queue a run of frames with rising time and occasional jumps
	task automatic queue_stream(int count, int unsigned max_step, int unsigned jump_pct);
		frame_t f;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < jump_pct)
				stream_ms = $urandom();
			else
				stream_ms = stream_ms + $urandom_range(0, max_step);
			f = make_frame(stream_ms);
			queue_frame(f.t, f.left, f.right);
		end
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_THRESHOLD: thr_cfg = data[THR_W-1:0];
			CFG_SUSTAIN:   sustain_cfg = data[MS_W-1:0];
			CFG_IGNORE:    ignore_cfg = data[MS_W-1:0];
			CFG_WINDOW:    window_cfg = data;
			default:       ;
		endcase
		cfg_writes++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_regs(logic [CFG_DATA_W-1:0] thr, logic [CFG_DATA_W-1:0] sus,
		logic [CFG_DATA_W-1:0] ign, logic [CFG_DATA_W-1:0] win);
		write_reg(CFG_THRESHOLD, thr);
		write_reg(CFG_SUSTAIN, sus);
		write_reg(CFG_IGNORE, ign);
		write_reg(CFG_WINDOW, win);
	endtask

	// Wait until every queued frame has produced its result
	task automatic wait_drained();
		while (results_seen < queued_total)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Frame driver: predict on each transaction, then offer the next frame
	always @(posedge clk) begin
		if (!arst_n) begin
			frm_if.valid <= 1'b0;
			frm_if.time_ms <= '0;
			frm_if.left_level <= '0;
			frm_if.right_level <= '0;
			gap_left <= 0;
		end else begin
			if (frm_if.valid && frm_if.ready) begin
				next_frame.t = frm_if.time_ms;
				next_frame.left = frm_if.left_level;
				next_frame.right = frm_if.right_level;
				tempo_q.push_back(predict_tempo(next_frame));
				frames_taken++;
			end
			if (!frm_if.valid || frm_if.ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					frm_if.valid <= 1'b0;
				end else if (frame_q.size() != 0) begin
					next_frame = frame_q.pop_front();
					frm_if.time_ms <= next_frame.t;
					frm_if.left_level <= next_frame.left;
					frm_if.right_level <= next_frame.right;
					frm_if.valid <= 1'b1;
					gap_left <= pick_gap();
				end else begin
					frm_if.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: check each transaction, stall ready at random
	always @(posedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			stall_left <= 0;
			hold_acks <= 0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				results_seen++;
				if (tempo_q.size() == 0) begin
					report_mismatch($sformatf("result beat=%0b bpm=%0d with no frame pending",
						res_if.beat, res_if.bpm));
				end else begin
					want = tempo_q.pop_front();
					if (res_if.beat !== want.beat)
						report_mismatch($sformatf("result %0d: beat %0b, expected %0b",
							results_seen, res_if.beat, want.beat));
					if (res_if.bpm !== want.bpm)
						report_mismatch($sformatf("result %0d: bpm %0d, expected %0d",
							results_seen, res_if.bpm, want.bpm));
					if (res_if.beats_tracked !== want.tracked)
						report_mismatch($sformatf("result %0d: beats_tracked %0d, expected %0d",
							results_seen, res_if.beats_tracked, want.tracked));
				end
			end
			if (hold_reqs != hold_acks) begin
				hold_acks <= hold_acks + 1;
				stall_left <= LONG_HOLD;
				res_if.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				res_if.ready <= 1'b0;
			end else if (take_stalls && $urandom_range(0, 99) < 12) begin
				stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3)
					: $urandom_range(10, 60);
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run when no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n || (frm_if.valid && frm_if.ready) || (res_if.valid && res_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_MAX) begin
			$display("beat_detect_bpm_estimator_top_tb: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		// hold every input at a known value through reset
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_THRESHOLD;
		cfg_data = '0;
		hold_reqs = 0;
		send_gaps = 1'b1;
		take_stalls = 1'b1;
		thr_cfg = THR_RST;
		sustain_cfg = SUSTAIN_RST;
		ignore_cfg = IGNORE_RST;
		window_cfg = WINDOW_RST;
		beat_mark = '0;
		ignore_mark = '0;
		beat_held = 1'b0;
		times_head = 0;
		times_count = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// beat at tick zero, threshold edges, time wrap, at reset values
		queue_frame(32'd0, 16'hFFFF, 16'hFFFF);
		queue_frame(32'd1, 16'hFFFF, 16'hFFFF);
		queue_frame(32'd2, 16'h0000, 16'h0000);
		queue_frame(32'd400, 16'd19660, 16'd0);
		queue_frame(32'd401, 16'd19661, 16'd0);
		queue_frame(32'd402, 16'd0, 16'hFFFF);
		queue_frame(32'd700, 16'd9830, 16'd9830);
		queue_frame(32'd701, 16'd9830, 16'd9831);
		queue_frame(32'hFFFF_FF00, 16'hFFFF, 16'hFFFF);
		queue_frame(32'hFFFF_FFFF, 16'h0000, 16'h0000);
		queue_frame(32'h0000_0200, 16'hFFFF, 16'hFFFF);
		queue_frame(32'h8000_0000, 16'hFFFF, 16'hFFFF);
		wait_drained();

		// zero timers and window: too few beats, zero span; junk in the high bits
		set_regs(32'hFFFE_0000, 32'hFFFF_0000, 32'hABCD_0000, 32'h0000_0000);
		queue_frame(32'd5000, 16'h0000, 16'h0000);
		queue_frame(32'd5000, 16'h0000, 16'h0000);
		queue_frame(32'd5001, 16'h0000, 16'h0000);
		wait_drained();
		// widest window: saturated estimate
		write_reg(CFG_WINDOW, 32'hFFFF_FFFF);
		queue_frame(32'd5001, 16'h0000, 16'h0000);
		queue_frame(32'd5002, 16'h0000, 16'h0000);
		queue_frame(32'd5002, 16'h0000, 16'h0000);
		wait_drained();

		// reset values with ordinary frame spacing
		set_regs(32'(THR_RST), 32'(SUSTAIN_RST), 32'(IGNORE_RST), WINDOW_RST);
		stream_ms = 32'd1000;
		queue_stream(250, 60, 0);
		wait_drained();

		// every frame beats: fill and overwrite the ring across the time wrap
		send_gaps = 1'b0;
		take_stalls = 1'b0;
		set_regs(32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
		stream_ms = 32'hFFFF_FF80;
		queue_stream(200, 6, 0);
		wait_drained();

		// top threshold and longest timers: no beat can fire
		send_gaps = 1'b1;
		take_stalls = 1'b1;
		set_regs(32'h0001_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, $urandom());
		queue_stream(80, 1000, 0);
		wait_drained();

		// back-pressure: hold results off while frames keep coming
		send_gaps = 1'b0;
		set_regs($urandom_range(10000, 40000), $urandom_range(0, 300),
			$urandom_range(0, 400), $urandom_range(500, 5000));
		queue_stream(300, 80, 0);
		while (frames_taken < queued_total - 280)
			@(posedge clk);
		hold_reqs++;
		wait_drained();

		// longest timers against long frame steps, empty window
		send_gaps = 1'b1;
		set_regs($urandom_range(0, 60000), 32'h0000_FFFF, 32'h0000_FFFF, 32'd0);
		queue_stream(150, 70000, 0);
		wait_drained();

		// random settings with junk high bits and random time jumps
		set_regs({15'($urandom()), 17'($urandom_range(0, 40000))},
			{16'($urandom()), 16'($urandom_range(0, 600))},
			{16'($urandom()), 16'($urandom_range(0, 600))}, $urandom());
		queue_stream(200, 500, 20);
		wait_drained();

		// reset values again with mixed spacing
		set_regs(32'(THR_RST), 32'(SUSTAIN_RST), 32'(IGNORE_RST), WINDOW_RST);
		queue_stream(220, 120, 2);
		wait_drained();
		repeat (TAIL) @(posedge clk);

		$display("Checked %0d results over %0d register writes: %0d beats, %0d ring overwrites,",
			results_seen, cfg_writes, beat_total, overwrite_total);
		$display("peak of %0d tracked beats, %0d saturated tempo estimates, %0d mismatches.",
			peak_tracked, sat_total, error_count);
		if (error_count == 0 && tempo_q.size() == 0)
			$display("beat_detect_bpm_estimator_top_tb: clean");
		else
			$display("beat_detect_bpm_estimator_top_tb: errors");
		$finish;
	end

endmodule
